FILE: hw/rtl/sfdp_pkg.sv
// Package for the sync-framed detection parser.
// Status codes, framing constants and the IEEE single compare helper.
// No dependencies.
package sfdp_pkg;

    localparam int unsigned SlotCountDefault     = 16;
    localparam int unsigned MaxFrameBytesDefault = 64;
    localparam int unsigned FrameLen             = 12;
    localparam int unsigned CountWidth           = 7;

    localparam logic [31:0] ThresholdReset = 32'h3F00_0000;

    localparam logic [7:0] SyncFirst  = 8'hFF;
    localparam logic [7:0] SyncSecond = 8'hFE;
    localparam logic [7:0] ByteCr     = 8'h0D;
    localparam logic [7:0] ByteLf     = 8'h0A;

    typedef enum logic [2:0] {
        STATUS_NONE     = 3'd0,
        STATUS_SYNC     = 3'd1,
        STATUS_STORED   = 3'd2,
        STATUS_RANGE    = 3'd3,
        STATUS_BAD_LEN  = 3'd4,
        STATUS_BAD_PAT  = 3'd5,
        STATUS_OVERFLOW = 3'd6
    } status_t;

    // Slot update request from the parser to the slot table
    typedef struct packed {
        logic       clear;
        logic       write;
        logic [7:0] index;
        logic       fire;
    } slot_req_t;

    // a >= b in IEEE single order; false when either is NaN
    function automatic logic float_ge(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        logic a_zero;
        logic b_zero;
        logic ge;
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (a_zero && b_zero)
        begin
            ge = 1'b1;
        end
        else if (a[31] != b[31])
        begin
            ge = !a[31];
        end
        else if (!a[31])
        begin
            ge = (a[30:0] >= b[30:0]);
        end
        else
        begin
            ge = (a[30:0] <= b[30:0]);
        end
        return ge && !a_nan && !b_nan;
    endfunction

endpackage

FILE: hw/rtl/sfdp_slots.sv
// Per-slot ready and fire flags with their summary outputs.
// Depends on sfdp_pkg.
module sfdp_slots
    import sfdp_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = SlotCountDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  slot_req_t req,
    output logic      all_ready,
    output logic      any_fire
);

    logic [SLOT_COUNT-1:0] ready_reg;
    logic [SLOT_COUNT-1:0] fire_reg;
    logic [SLOT_COUNT-1:0] ready_next;
    logic [SLOT_COUNT-1:0] fire_next;

    // Apply clear or single-slot write
    always_comb
    begin
        ready_next = ready_reg;
        fire_next  = fire_reg;
        if (req.clear)
        begin
            ready_next = '0;
            fire_next  = '0;
        end
        else if (req.write)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (req.index == 8'(i))
                begin
                    ready_next[i] = 1'b1;
                    fire_next[i]  = req.fire;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
            fire_reg  <= '0;
        end
        else if (en)
        begin
            ready_reg <= ready_next;
            fire_reg  <= fire_next;
        end
    end

    assign all_ready = &ready_next;
    assign any_fire  = |(ready_next & fire_next);

endmodule

FILE: hw/rtl/sfdp_parser.sv
// Sync hunt, frame capture and frame check for one byte per transaction.
// Depends on sfdp_pkg.
module sfdp_parser
    import sfdp_pkg::*;
#(
    parameter int unsigned SLOT_COUNT      = SlotCountDefault,
    parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    input  logic [31:0] threshold,
    output slot_req_t   req,
    output status_t     status,
    output logic [7:0]  frame_index,
    output logic [31:0] probability_bits,
    output logic        fire_event
);

    logic                  capturing_reg;
    logic                  capturing_next;
    logic [7:0]            hunt_reg;
    logic [7:0]            hunt_next;
    logic [7:0]            cap_reg [FrameLen];
    logic [7:0]            cap_next [FrameLen];
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic [7:0]            prev_reg;
    logic [7:0]            prev_next;
    logic                  pattern_ok;
    logic [31:0]           prob;

    // Bytes 1..4 little endian after this byte lands
    assign prob = {cap_next[4], cap_next[3], cap_next[2], cap_next[1]};
    assign pattern_ok = (cap_next[5] == 8'h01) && (cap_next[6] == 8'h02)
        && (cap_next[7] == 8'h03) && (cap_next[8] == 8'h04)
        && (cap_next[9] == 8'h05);

    always_comb
    begin
        capturing_next   = capturing_reg;
        hunt_next        = hunt_reg;
        cap_next         = cap_reg;
        count_next       = count_reg;
        prev_next        = prev_reg;
        status           = STATUS_NONE;
        frame_index      = '0;
        probability_bits = '0;
        fire_event       = 1'b0;
        req              = '0;
        if (cmd)
        begin
            req.clear = 1'b1;
        end
        else if (!capturing_reg)
        begin
            // Hunt for the sync pair
            if (data_byte == SyncSecond && hunt_reg == SyncFirst)
            begin
                capturing_next = 1'b1;
                count_next     = '0;
                prev_next      = '0;
                for (int i = 0; i < FrameLen; i++)
                begin
                    cap_next[i] = '0;
                end
                status = STATUS_SYNC;
            end
            else
            begin
                hunt_next = data_byte;
            end
        end
        else if (count_reg >= CountWidth'(MAX_FRAME_BYTES))
        begin
            // Drop the overlong frame
            status         = STATUS_OVERFLOW;
            capturing_next = 1'b0;
            hunt_next      = '0;
        end
        else
        begin
            // Capture and check for frame end
            for (int i = 0; i < FrameLen; i++)
            begin
                if (count_reg == CountWidth'(i))
                begin
                    cap_next[i] = data_byte;
                end
            end
            count_next = count_reg + CountWidth'(1);
            prev_next  = data_byte;
            if (data_byte == ByteLf && prev_reg == ByteCr)
            begin
                capturing_next = 1'b0;
                hunt_next      = '0;
                if (count_next != CountWidth'(FrameLen))
                begin
                    status = STATUS_BAD_LEN;
                end
                else if (!pattern_ok)
                begin
                    status = STATUS_BAD_PAT;
                end
                else
                begin
                    frame_index      = cap_next[0];
                    probability_bits = prob;
                    fire_event       = float_ge(prob, threshold);
                    if (32'(cap_next[0]) < 32'(SLOT_COUNT))
                    begin
                        status    = STATUS_STORED;
                        req.write = 1'b1;
                        req.index = cap_next[0];
                        req.fire  = fire_event;
                    end
                    else
                    begin
                        status = STATUS_RANGE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg <= 1'b0;
            hunt_reg      <= '0;
            count_reg     <= '0;
            prev_reg      <= '0;
            for (int i = 0; i < FrameLen; i++)
            begin
                cap_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            capturing_reg <= capturing_next;
            hunt_reg      <= hunt_next;
            count_reg     <= count_next;
            prev_reg      <= prev_next;
            cap_reg       <= cap_next;
        end
    end

endmodule

FILE: hw/rtl/sync_framed_detection_parser.sv
// Sync-framed detection parser: top level with input and result registers.
// Path: input register, single-pass parser, result register; the result is
// registered after the input transaction. Throughput: one byte per cycle; a
// stalled result holds both registers, and in_ready drops only while both are full.
// Reset (rst_n, async, active low): hunting, all slots clear, threshold 0.5.
module sync_framed_detection_parser
    import sfdp_pkg::*;
#(
    parameter int unsigned SLOT_COUNT      = SlotCountDefault,
    parameter int unsigned MAX_FRAME_BYTES = MaxFrameBytesDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  frame_index,
    output logic [31:0] probability_bits,
    output logic        fire_event,
    output logic        all_frames_ready,
    output logic        any_fire
);

    logic        cfg_write;
    logic [31:0] threshold_reg;
    logic        in_full_reg;
    logic        cmd_reg;
    logic [7:0]  byte_reg;
    logic        out_full_reg;
    logic        advance;
    slot_req_t   req;
    status_t     st;
    logic [7:0]  fnum;
    logic [31:0] pbits;
    logic        fire;
    logic        all_rdy;
    logic        any_f;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ThresholdReset;
        end
        else if (cfg_write)
        begin
            threshold_reg <= cfg_data;
        end
    end

    // Advance the input register into the result register
    assign advance  = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= cmd;
            byte_reg <= data_byte;
        end
    end

    sfdp_parser #(
        .SLOT_COUNT      (SLOT_COUNT),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (advance),
        .cmd              (cmd_reg),
        .data_byte        (byte_reg),
        .threshold        (threshold_reg),
        .req              (req),
        .status           (st),
        .frame_index      (fnum),
        .probability_bits (pbits),
        .fire_event       (fire)
    );

    sfdp_slots #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .req       (req),
        .all_ready (all_rdy),
        .any_fire  (any_f)
    );

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_full_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status           <= st;
            frame_index      <= fnum;
            probability_bits <= pbits;
            fire_event       <= fire;
            all_frames_ready <= all_rdy;
            any_fire         <= any_f;
        end
    end

    assign out_valid = out_full_reg;

endmodule

FILE: hw/rtl/sfdp_checker.sv
// Port-level checker for the sync-framed detection parser, bound to the top.
// Depends on sfdp_pkg.
module sfdp_checker
    import sfdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [7:0]  frame_index,
    input  logic [31:0] probability_bits,
    input  logic        fire_event
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(probability_bits))
        else $error("result changed while stalled");

    // Status stays in its coded range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 3'(STATUS_OVERFLOW))
        else $error("status out of range");

    // Frame fields are zero unless a well-formed frame is reported
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 3'(STATUS_STORED) && status != 3'(STATUS_RANGE)
            |-> frame_index == 8'd0 && probability_bits == 32'd0 && !fire_event)
        else $error("frame fields set without a frame");

    // Stored status means an in-range index
    a_stored_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == 3'(STATUS_STORED) |-> 32'(frame_index) < SlotCountDefault)
        else $error("stored index out of range");

    // An accepted byte yields a result, checked when no result is pending
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> ##1 out_valid)
        else $error("result missing");

endmodule

bind sync_framed_detection_parser sfdp_checker u_sfdp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .frame_index      (frame_index),
    .probability_bits (probability_bits),
    .fire_event       (fire_event)
);
